// ----- hdl/ldir_pkg.sv -----
package ldir_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int KB_W  = 24;
    localparam int EB_W  = 17;

    localparam logic [1:0] ST_INVALID  = 2'd0;
    localparam logic [1:0] ST_VALID    = 2'd1;
    localparam logic [1:0] ST_MODIFIED = 2'd2;

    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_UNLOAD = 3'd1;
    localparam logic [2:0] REQ_GET    = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_SYNC   = 3'd4;
    localparam logic [2:0] REQ_INVAL  = 3'd5;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_SIZE  = 3'd1;
    localparam logic [2:0] STS_CACHED    = 3'd2;
    localparam logic [2:0] STS_NO_SPACE  = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STS_BUF_SMALL = 3'd5;
    localparam logic [2:0] STS_LINE_INV  = 3'd6;
    localparam logic [2:0] STS_TOO_LARGE = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] model_number;
        logic [3:0]  line_number;
        logic [31:0] byte_count;
        logic [31:0] msg_version;
    } t_req_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [16:0]      result_value;
        logic [KB_W-1:0]  used_kb_now;
        logic [CNT_W-1:0] lines_in_use;
    } t_rsp_out;

    typedef struct packed {
        logic [15:0]     model;
        logic [3:0]      line;
        logic [EB_W-1:0] bytes;
        logic [1:0]      state;
        logic [31:0]     version;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

endpackage

// ----- hdl/ldir_mem.sv -----
module ldir_mem (
    input  logic                            i_clk,
    input  ldir_pkg::t_mem_wr               i_wr,
    input  logic [ldir_pkg::IDX_W-1:0]      i_raddr,
    output ldir_pkg::t_entry                o_rdata
);
    import ldir_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ldir_seq.sv -----
module ldir_seq #(
    parameter int LINE_KB         = 64,
    parameter int LINES_PER_MODEL = 16,
    parameter int MAX_MODELS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ldir_pkg::t_req_in           i_req,
    input  logic [ldir_pkg::KB_W-1:0]   i_capacity_kb,
    output logic                        o_idle,
    output logic                        o_done,
    input  logic                        i_ack,
    output ldir_pkg::t_rsp_out          o_rsp
);
    import ldir_pkg::*;

    localparam logic [32:0] LINE_BYTES = 33'(LINE_KB * 1024);
    localparam int LIMIT_I = (MAX_MODELS * LINES_PER_MODEL < DEPTH) ?
                             MAX_MODELS * LINES_PER_MODEL : DEPTH;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_I);
    localparam logic [CNT_W-1:0] LPM   = CNT_W'(LINES_PER_MODEL);
    localparam logic [25:0]      KB_PER_LINE = 26'(LINE_KB);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_EX    = 7'b0000100,
        S_CNT   = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_ALLOC = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    t_req_in          r_req, n_req;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [KB_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0] r_hits, n_hits;
    logic [2:0]       r_status, n_status;
    logic [16:0]      r_value, n_value;
    logic [31:0]      r_rem, n_rem;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_i, n_i;

    t_mem_wr          w_wr;
    t_entry           w_rd;
    logic [IDX_W-1:0] w_raddr;
    logic [25:0]      w_need_kb, w_freed;
    logic             w_match_model, w_match_line, w_rem_fits;
    logic [32:0]      w_last_bytes;

    ldir_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_raddr       = r_idx[IDX_W-1:0];
    assign w_need_kb     = 26'(r_n) * KB_PER_LINE;
    assign w_freed       = 26'(r_hits) * KB_PER_LINE;
    assign w_match_model = (w_rd.model == r_req.model_number);
    assign w_match_line  = w_match_model && (w_rd.line == r_req.line_number);
    assign w_rem_fits    = ({1'b0, r_rem} <= LINE_BYTES);
    assign w_last_bytes  = w_rem_fits ? {1'b0, r_rem} : LINE_BYTES;

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_wptr   = r_wptr;
        n_cnt    = r_cnt;
        n_used   = r_used;
        n_hits   = r_hits;
        n_status = r_status;
        n_value  = r_value;
        n_rem    = r_rem;
        n_n      = r_n;
        n_i      = r_i;
        w_wr     = '0;
        w_wr.data = w_rd;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_wptr   = '0;
                    n_hits   = '0;
                    n_value  = '0;
                    n_status = STS_OK;
                    if ((i_req.req_type == REQ_LOAD || i_req.req_type == REQ_GET ||
                         i_req.req_type == REQ_WRITE) && i_req.byte_count == '0) begin
                        n_status = STS_BAD_SIZE;
                        n_state  = S_DONE;
                    end else if (i_req.req_type > REQ_INVAL) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_idx < r_cnt) begin
                    n_state = S_EX;
                end else begin
                    n_state = S_DONE;
                    case (r_req.req_type)
                        REQ_LOAD: begin
                            n_rem   = r_req.byte_count;
                            n_n     = '0;
                            n_state = S_CNT;
                        end
                        REQ_UNLOAD: begin
                            n_cnt    = r_wptr;
                            n_used   = (w_freed >= 26'(r_used)) ? '0 :
                                       r_used - w_freed[KB_W-1:0];
                            n_status = (r_hits != '0) ? STS_OK : STS_NOT_FOUND;
                        end
                        REQ_INVAL: n_value = 17'(r_hits);
                        default:   n_status = STS_NOT_FOUND;
                    endcase
                end
            end
            S_EX: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_RD;
                case (r_req.req_type)
                    REQ_LOAD: begin
                        if (w_match_model && w_rd.state != ST_INVALID) begin
                            n_status = STS_CACHED;
                            n_state  = S_DONE;
                        end
                    end
                    REQ_UNLOAD: begin
                        // Surviving entries slide down over the removed ones.
                        if (w_match_model) begin
                            n_hits = r_hits + 1'b1;
                        end else begin
                            w_wr.en   = 1'b1;
                            w_wr.addr = r_wptr[IDX_W-1:0];
                            n_wptr    = r_wptr + 1'b1;
                        end
                    end
                    REQ_GET: begin
                        if (w_match_line) begin
                            n_state = S_DONE;
                            if (32'(w_rd.bytes) > r_req.byte_count) begin
                                n_status = STS_BUF_SMALL;
                            end else if (w_rd.state == ST_INVALID) begin
                                n_status = STS_LINE_INV;
                            end else begin
                                n_value = w_rd.bytes;
                            end
                        end
                    end
                    REQ_WRITE: begin
                        if (w_match_line) begin
                            n_state = S_DONE;
                            if ({1'b0, r_req.byte_count} > LINE_BYTES) begin
                                n_status = STS_TOO_LARGE;
                            end else begin
                                w_wr.en           = 1'b1;
                                w_wr.addr         = r_idx[IDX_W-1:0];
                                w_wr.data.state   = ST_MODIFIED;
                                w_wr.data.version = w_rd.version + 32'd1;
                            end
                        end
                    end
                    REQ_SYNC: begin
                        if (w_match_line) begin
                            n_state = S_DONE;
                            if (w_rd.state == ST_MODIFIED) begin
                                w_wr.en         = 1'b1;
                                w_wr.addr       = r_idx[IDX_W-1:0];
                                w_wr.data.state = ST_VALID;
                            end
                        end
                    end
                    default: begin
                        if (w_match_model && w_rd.version < r_req.msg_version) begin
                            w_wr.en           = 1'b1;
                            w_wr.addr         = r_idx[IDX_W-1:0];
                            w_wr.data.state   = ST_INVALID;
                            w_wr.data.version = r_req.msg_version;
                            n_hits            = r_hits + 1'b1;
                        end
                    end
                endcase
            end
            S_CNT: begin
                // Count lines by repeated subtraction of one line of bytes.
                n_n = r_n + 1'b1;
                if (w_rem_fits || (r_n + 1'b1) == LPM) begin
                    n_state = S_CHK;
                end else begin
                    n_rem = r_rem - LINE_BYTES[31:0];
                end
            end
            S_CHK: begin
                if (26'(r_used) + w_need_kb > 26'(i_capacity_kb)) begin
                    n_status = STS_NO_SPACE;
                    n_state  = S_DONE;
                end else begin
                    n_rem   = r_req.byte_count;
                    n_i     = '0;
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (r_i < r_n && r_cnt < LIMIT) begin
                    w_wr.en           = 1'b1;
                    w_wr.addr         = r_cnt[IDX_W-1:0];
                    w_wr.data.model   = r_req.model_number;
                    w_wr.data.line    = r_i[3:0];
                    w_wr.data.bytes   = (r_i == r_n - 1'b1) ? w_last_bytes[EB_W-1:0] :
                                        LINE_BYTES[EB_W-1:0];
                    w_wr.data.state   = ST_VALID;
                    w_wr.data.version = 32'd1;
                    n_cnt = r_cnt + 1'b1;
                    n_rem = r_rem - LINE_BYTES[31:0];
                    n_i   = r_i + 1'b1;
                end else begin
                    n_used  = r_used + w_need_kb[KB_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_wptr   <= n_wptr;
        r_hits   <= n_hits;
        r_status <= n_status;
        r_value  <= n_value;
        r_rem    <= n_rem;
        r_n      <= n_n;
        r_i      <= n_i;
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_done             = (r_state == S_DONE);
    assign o_rsp.status       = r_status;
    assign o_rsp.result_value = r_value;
    assign o_rsp.used_kb_now  = r_used;
    assign o_rsp.lines_in_use = r_cnt;

endmodule

// ----- hdl/model_line_directory_unit.sv -----
// Each item scans the table entry by entry; a load then counts the lines that it needs,
// checks them against the capacity and writes the new lines in turn.
// One item at a time: a new item is taken once the previous one has moved to the
// output register, as the table memory and its one compare unit are stepped in turn.
// Reset clears the entry count, the used KB and the capacity register.
module model_line_directory_unit #(
    parameter int LINE_KB         = 64,
    parameter int LINES_PER_MODEL = 16,
    parameter int MAX_MODELS      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ldir_pkg::t_req_in           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ldir_pkg::t_rsp_out          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [ldir_pkg::KB_W-1:0]   i_cfg_data
);
    import ldir_pkg::*;

    logic [KB_W-1:0] r_capacity;
    logic            r_out_valid;
    t_rsp_out        r_out_data;
    logic            w_idle, w_done, w_ack;
    t_rsp_out        w_rsp;

    ldir_seq #(
        .LINE_KB         (LINE_KB),
        .LINES_PER_MODEL (LINES_PER_MODEL),
        .MAX_MODELS      (MAX_MODELS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in_valid),
        .i_req         (i_in_data),
        .i_capacity_kb (r_capacity),
        .o_idle        (w_idle),
        .o_done        (w_done),
        .i_ack         (w_ack),
        .o_rsp         (w_rsp)
    );

    // A finished item moves to the output register once that register is free.
    assign w_ack = w_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_ack) begin
            r_out_data <= w_rsp;
        end
    end

    assign o_in_ready  = w_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- sim/tb_model_line_directory_unit.sv -----
module tb_model_line_directory_unit;
    import ldir_pkg::*;

    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int LINE_BYTES = 65536;
    localparam int LINE_KB_C  = 64;
    localparam int MAX_LINES  = 16;
    localparam int TABLE_MAX  = 256;
    localparam int SETTLE     = 600;
    localparam int STALL_LIMIT = 5000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_req_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_rsp_out o_out_data;
    logic     i_cfg_we = 1'b0;
    logic [KB_W-1:0] i_cfg_data = '0;

    model_line_directory_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the line directory.
    logic [15:0]     dir_model [TABLE_MAX];
    logic [3:0]      dir_line  [TABLE_MAX];
    logic [EB_W-1:0] dir_bytes [TABLE_MAX];
    logic [1:0]      dir_state [TABLE_MAX];
    logic [31:0]     dir_ver   [TABLE_MAX];
    int unsigned     dir_count = 0;
    logic [KB_W-1:0] kb_used = '0;
    logic [KB_W-1:0] cap_kb = '0;

    t_rsp_out pending_rsp [$];
    int  errors = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    function automatic int locate_line(logic [15:0] m, logic [3:0] l);
        for (int i = 0; i < dir_count; i++) begin
            if (dir_model[i] == m && dir_line[i] == l) return i;
        end
        return -1;
    endfunction

    function automatic t_rsp_out predict_directory(t_req_in r);
        t_rsp_out  o;
        int        k;
        int        w;
        int        removed;
        longint    need;
        longint    last;
        o = '0;
        case (r.req_type)
            REQ_LOAD: begin
                if (r.byte_count == 0) begin
                    o.status = STS_BAD_SIZE;
                end else begin
                    for (int i = 0; i < dir_count; i++) begin
                        if (dir_model[i] == r.model_number && dir_state[i] != ST_INVALID)
                            o.status = STS_CACHED;
                    end
                    if (o.status == STS_OK) begin
                        need = (longint'(r.byte_count) + LINE_BYTES - 1) / LINE_BYTES;
                        if (need > MAX_LINES) need = MAX_LINES;
                        if (longint'(kb_used) + need * LINE_KB_C > longint'(cap_kb)) begin
                            o.status = STS_NO_SPACE;
                        end else begin
                            for (int i = 0; i < need && dir_count < TABLE_MAX; i++) begin
                                dir_model[dir_count] = r.model_number;
                                dir_line[dir_count] = i[3:0];
                                if (i == need - 1) begin
                                    last = longint'(r.byte_count) - longint'(i) * LINE_BYTES;
                                    if (last > LINE_BYTES) last = LINE_BYTES;
                                    dir_bytes[dir_count] = last[EB_W-1:0];
                                end else begin
                                    dir_bytes[dir_count] = EB_W'(LINE_BYTES);
                                end
                                dir_state[dir_count] = ST_VALID;
                                dir_ver[dir_count] = 32'd1;
                                dir_count++;
                            end
                            kb_used = kb_used + KB_W'(need * LINE_KB_C);
                        end
                    end
                end
            end
            REQ_UNLOAD: begin
                w = 0;
                removed = 0;
                for (int i = 0; i < dir_count; i++) begin
                    if (dir_model[i] == r.model_number) begin
                        removed++;
                    end else begin
                        dir_model[w] = dir_model[i];
                        dir_line[w] = dir_line[i];
                        dir_bytes[w] = dir_bytes[i];
                        dir_state[w] = dir_state[i];
                        dir_ver[w] = dir_ver[i];
                        w++;
                    end
                end
                dir_count = w;
                if (removed * LINE_KB_C >= kb_used) kb_used = '0;
                else kb_used = kb_used - KB_W'(removed * LINE_KB_C);
                if (removed == 0) o.status = STS_NOT_FOUND;
            end
            REQ_GET: begin
                k = locate_line(r.model_number, r.line_number);
                if (r.byte_count == 0) o.status = STS_BAD_SIZE;
                else if (k < 0) o.status = STS_NOT_FOUND;
                else if (dir_bytes[k] > r.byte_count) o.status = STS_BUF_SMALL;
                else if (dir_state[k] == ST_INVALID) o.status = STS_LINE_INV;
                else o.result_value = dir_bytes[k];
            end
            REQ_WRITE: begin
                k = locate_line(r.model_number, r.line_number);
                if (r.byte_count == 0) o.status = STS_BAD_SIZE;
                else if (k < 0) o.status = STS_NOT_FOUND;
                else if (r.byte_count > LINE_BYTES) o.status = STS_TOO_LARGE;
                else begin
                    dir_state[k] = ST_MODIFIED;
                    dir_ver[k] = dir_ver[k] + 32'd1;
                end
            end
            REQ_SYNC: begin
                k = locate_line(r.model_number, r.line_number);
                if (k < 0) o.status = STS_NOT_FOUND;
                else if (dir_state[k] == ST_MODIFIED) dir_state[k] = ST_VALID;
            end
            REQ_INVAL: begin
                for (int i = 0; i < dir_count; i++) begin
                    if (dir_model[i] == r.model_number && dir_ver[i] < r.msg_version) begin
                        dir_state[i] = ST_INVALID;
                        dir_ver[i] = r.msg_version;
                        o.result_value = o.result_value + 17'd1;
                    end
                end
            end
            default: ;
        endcase
        o.used_kb_now = kb_used;
        o.lines_in_use = dir_count[CNT_W-1:0];
        return o;
    endfunction

    function automatic t_req_in random_request();
        t_req_in r;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) r.req_type = REQ_LOAD;
        else if (pick < 30) r.req_type = REQ_UNLOAD;
        else if (pick < 55) r.req_type = REQ_GET;
        else if (pick < 75) r.req_type = REQ_WRITE;
        else if (pick < 85) r.req_type = REQ_SYNC;
        else if (pick < 97) r.req_type = REQ_INVAL;
        else r.req_type = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
        // A small pool of models keeps hits and duplicates frequent.
        r.model_number = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 19))
                                                       : 16'($urandom);
        r.line_number = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0: r.byte_count = 32'd0;
            1: r.byte_count = $urandom;
            2: r.byte_count = $urandom_range(1, LINE_BYTES);
            3: r.byte_count = LINE_BYTES;
            4: r.byte_count = LINE_BYTES + 1;
            5: r.byte_count = $urandom_range(1, 1048576);
            default: r.byte_count = $urandom_range(1, 200000);
        endcase
        r.msg_version = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8);
        return r;
    endfunction

    task automatic send_item(t_req_in r, bit typed, logic [2:0] st, logic [16:0] val);
        t_rsp_out e;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_data <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        e = predict_directory(r);
        if (typed) begin
            e.status = st;
            e.result_value = val;
        end
        pending_rsp.push_back(e);
    endtask

    task automatic set_capacity(logic [KB_W-1:0] kb);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_data <= kb;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cap_kb = kb;
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_item(random_request(), 1'b0, STS_OK, '0);
    endtask

    typedef struct {
        logic [2:0]  req;
        logic [15:0] model;
        logic [3:0]  line;
        logic [31:0] bytes;
        logic [31:0] ver;
        bit          typed;
        logic [2:0]  st;
        logic [16:0] val;
    } t_dir_row;

    // The first four rows run with no capacity, the rest with the largest one.
    t_dir_row dir_rows [25] = '{
        '{REQ_LOAD,   16'd1,      4'd0,  32'd100,        32'd0, 1, STS_NO_SPACE,  17'd0},
        '{REQ_GET,    16'd1,      4'd0,  32'd0,          32'd0, 1, STS_BAD_SIZE,  17'd0},
        '{REQ_UNLOAD, 16'd5,      4'd0,  32'd0,          32'd0, 1, STS_NOT_FOUND, 17'd0},
        '{REQ_SPARE6, 16'd1,      4'd3,  32'd7,          32'd9, 1, STS_OK,        17'd0},
        '{REQ_LOAD,   16'd1,      4'd0,  32'd1,          32'd0, 1, STS_OK,        17'd0},
        '{REQ_LOAD,   16'd1,      4'd0,  32'd1,          32'd0, 1, STS_CACHED,    17'd0},
        '{REQ_LOAD,   16'hFFFF,   4'd0,  32'hFFFFFFFF,   32'd0, 1, STS_OK,        17'd0},
        '{REQ_GET,    16'hFFFF,   4'd15, 32'hFFFFFFFF,   32'd0, 1, STS_OK,        17'd65536},
        '{REQ_GET,    16'd1,      4'd0,  32'd1,          32'd0, 1, STS_OK,        17'd1},
        '{REQ_LOAD,   16'd3,      4'd0,  32'd0,          32'd0, 1, STS_BAD_SIZE,  17'd0},
        '{REQ_WRITE,  16'd1,      4'd0,  32'd65537,      32'd0, 1, STS_TOO_LARGE, 17'd0},
        '{REQ_WRITE,  16'd1,      4'd0,  32'd0,          32'd0, 1, STS_BAD_SIZE,  17'd0},
        '{REQ_WRITE,  16'd1,      4'd0,  32'd65536,      32'd0, 1, STS_OK,        17'd0},
        '{REQ_SYNC,   16'd1,      4'd0,  32'd0,          32'd0, 1, STS_OK,        17'd0},
        '{REQ_SYNC,   16'd1,      4'd5,  32'd0,          32'd0, 1, STS_NOT_FOUND, 17'd0},
        '{REQ_INVAL,  16'd1,      4'd0,  32'd0, 32'hFFFFFFFF, 1, STS_OK,        17'd1},
        '{REQ_GET,    16'd1,      4'd0,  32'd100,        32'd0, 1, STS_LINE_INV,  17'd0},
        '{REQ_GET,    16'hFFFF,   4'd0,  32'd10,         32'd0, 1, STS_BUF_SMALL, 17'd0},
        '{REQ_WRITE,  16'd1,      4'd0,  32'd5,          32'd0, 1, STS_OK,        17'd0},
        '{REQ_INVAL,  16'd1,      4'd0,  32'd0,          32'd1, 1, STS_OK,        17'd1},
        '{REQ_LOAD,   16'd1,      4'd0,  32'd65537,      32'd0, 1, STS_OK,        17'd0},
        '{REQ_GET,    16'd1,      4'd1,  32'd65536,      32'd0, 0, STS_OK,        17'd0},
        '{REQ_UNLOAD, 16'd1,      4'd0,  32'd0,          32'd0, 1, STS_OK,        17'd0},
        '{REQ_SPARE7, 16'hFFFF,   4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, STS_OK,   17'd0},
        '{REQ_INVAL,  16'hFFFF,   4'd0,  32'd0,          32'd0, 1, STS_OK,        17'd0}
    };

    initial begin
        t_req_in r;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 25; i++) begin
            if (i == 4) set_capacity(24'hFFFFFF);
            r.req_type = dir_rows[i].req;
            r.model_number = dir_rows[i].model;
            r.line_number = dir_rows[i].line;
            r.byte_count = dir_rows[i].bytes;
            r.msg_version = dir_rows[i].ver;
            send_item(r, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].val);
        end
        random_phase(400);
        set_capacity(24'd2560);
        random_phase(250);
        set_capacity(24'($urandom));
        hold_req = 1'b1;
        random_phase(250);
        set_capacity(24'hFFFFFF);
        random_phase(100);
        idle_on = 1'b0;
        random_phase(100);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        t_rsp_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected item status=%0d", o_out_data.status);
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                if (o_out_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.result_value !== e.result_value) begin
                    $error("result_value exp %0d got %0d", e.result_value,
                           o_out_data.result_value);
                    errors++;
                end
                if (o_out_data.used_kb_now !== e.used_kb_now) begin
                    $error("used_kb_now exp %0d got %0d", e.used_kb_now,
                           o_out_data.used_kb_now);
                    errors++;
                end
                if (o_out_data.lines_in_use !== e.lines_in_use) begin
                    $error("lines_in_use exp %0d got %0d", e.lines_in_use,
                           o_out_data.lines_in_use);
                    errors++;
                end
            end
        end
        if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
